>>> design/rff_pkg.sv
// Package for the row FIR filter: shared widths, reset values, register codes
// and the job width helper. No dependencies.
`timescale 1ns / 1ps

package rff_pkg;

  localparam int PIX_W       = 16;
  localparam int TAP_W       = 16;
  localparam int ACC_W       = 32;
  localparam int SUM_SHIFT   = 16;
  localparam int NUM_TAPS    = 16;
  localparam int TAP_IW      = 4;
  localparam int NUM_TAP_REG = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IW      = 3;
  localparam int ROW_WIDTH_W = 13;
  localparam int RADIUS_W    = 3;

  localparam int MAX_RADIUS_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd640;
  localparam logic [RADIUS_W-1:0]    RADIUS_RST    = 3'd1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROW_WIDTH  = 3'd0,
    CFG_RADIUS     = 3'd1,
    CFG_TAPS_0_3   = 3'd2,
    CFG_TAPS_4_7   = 3'd3,
    CFG_TAPS_8_11  = 3'd4,
    CFG_TAPS_12_15 = 3'd5
  } cfg_idx_t;

  typedef logic [NUM_TAPS-1:0][TAP_W-1:0] taps_t;

  // window + column + first/last column + end flag + radius
  function automatic int job_width(input int max_radius, input int max_width);
    job_width = (2 * max_radius + 1) * PIX_W + 3 * $clog2(max_width) + 1
                + $clog2(max_radius + 1);
  endfunction

endpackage

>>> design/rff_queue.sv
// Short job queue between the filter front and back ends.
// Depends on rff_pkg for the default depth.
`timescale 1ns / 1ps

module rff_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = rff_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] head_data
);

  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full      = count_r == (PW+1)'(DEPTH);
  assign valid     = count_r != '0;
  assign head_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> design/rff_front.sv
// Filter front end: takes pixel beats, keeps the pixel window and column
// count, and queues one job per pixel that produces results. Uses rff_pkg.
`timescale 1ns / 1ps

module rff_front #(
  parameter int MAX_RADIUS = rff_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = rff_pkg::MAX_WIDTH_DEF,
  parameter int JW         = rff_pkg::job_width(MAX_RADIUS, MAX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rff_pkg::PIX_W-1:0]        in_tdata,   // [15:0] pixel
  input  logic [rff_pkg::ROW_WIDTH_W-1:0]  row_width,
  input  logic [rff_pkg::RADIUS_W-1:0]     radius,
  input  logic                             q_full,
  output logic                             push,
  output logic [JW-1:0]                    job_data
);

  localparam int WD = 2 * MAX_RADIUS + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_RADIUS + 1);

  typedef struct packed {
    logic [WD-1:0][rff_pkg::PIX_W-1:0] win;
    logic [CW-1:0]                     c;
    logic [CW-1:0]                     xf;
    logic [CW-1:0]                     xl;
    logic                              ends;
    logic [RW-1:0]                     r;
  } job_t;

  logic [WD-1:0][rff_pkg::PIX_W-1:0] win_r, win_nxt;
  logic [CW-1:0]                     col_r, col_nxt;
  logic                              accept;
  logic [RW-1:0]                     r_eff;
  logic [31:0]                       w_eff;
  logic                              ends;
  logic                              has_result;
  job_t                              job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  always_comb begin
    r_eff = (32'(radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);
    w_eff = (row_width == '0 || 32'(row_width) > 32'(MAX_WIDTH)) ?
            32'(MAX_WIDTH) : 32'(row_width);
    ends       = 32'(col_r) + 32'd1 >= w_eff;
    has_result = col_r >= CW'(r_eff);
    col_nxt    = ends ? '0 : col_r + 1'b1;

    win_nxt[0] = in_tdata;
    for (int k = 1; k < WD; k++) begin
      win_nxt[k] = win_r[k-1];
    end

    job.win  = win_nxt;
    job.c    = col_r;
    job.xf   = has_result ? col_r - CW'(r_eff) : '0;
    job.xl   = ends ? col_r : job.xf;
    job.ends = ends;
    job.r    = r_eff;
  end

  assign push     = accept && (ends || has_result);
  assign job_data = job;

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
    end
  end

endmodule

>>> design/rff_back.sv
// Filter back end: pops jobs and runs one multiply-accumulate per tap for
// each result column, then hands results to the output register. Uses rff_pkg.
`timescale 1ns / 1ps

module rff_back #(
  parameter int MAX_RADIUS = rff_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = rff_pkg::MAX_WIDTH_DEF,
  parameter int JW         = rff_pkg::job_width(MAX_RADIUS, MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [JW-1:0]              q_data,
  output logic                       pop,
  input  rff_pkg::taps_t             taps,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rff_pkg::PIX_W-1:0]  out_tdata,  // [15:0] filtered
  output logic                       out_tlast
);

  localparam int WD = 2 * MAX_RADIUS + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int AW = $clog2(WD);

  typedef struct packed {
    logic [WD-1:0][rff_pkg::PIX_W-1:0] win;
    logic [CW-1:0]                     c;
    logic [CW-1:0]                     xf;
    logic [CW-1:0]                     xl;
    logic                              ends;
    logic [RW-1:0]                     r;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_SUM  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  job_t                          job_r, job_nxt;
  logic [CW-1:0]                 x_r, x_nxt;
  logic [RW:0]                   j_r, j_nxt;
  logic [rff_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [rff_pkg::ACC_W-1:0]     prod_r, prod_nxt;
  logic                          pv_r, pv_nxt;
  logic                          ov_r, ov_nxt;
  logic [rff_pkg::PIX_W-1:0]     od_r, od_nxt;
  logic                          ol_r, ol_nxt;

  logic [RW-1:0]                 d, lo;
  logic [RW:0]                   hi, age, two_r;
  logic                          tap_ok;
  logic [rff_pkg::PIX_W-1:0]     pix;
  logic [rff_pkg::TAP_W-1:0]     tap;
  logic                          out_free, at_last;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  // tap j of column x reads the pixel of age d + r - j
  always_comb begin
    d      = RW'(job_r.c - x_r);
    lo     = (x_r < CW'(job_r.r)) ? job_r.r - x_r[RW-1:0] : '0;
    hi     = {1'b0, d} + {1'b0, job_r.r};
    age    = hi - j_r;
    two_r  = {job_r.r, 1'b0};
    tap_ok = j_r >= {1'b0, lo} && j_r <= hi;
    pix    = tap_ok ? job_r.win[AW'(age)] : '0;
    tap    = taps[rff_pkg::TAP_IW'(j_r)];
  end

  assign out_free = !ov_r || out_tready;
  assign at_last  = x_r == job_r.xl;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    x_nxt     = x_r;
    j_nxt     = j_r;
    acc_nxt   = pv_r ? acc_r + prod_r : acc_r;
    pv_nxt    = state_r == S_MAC;
    prod_nxt  = rff_pkg::ACC_W'(pix) * rff_pkg::ACC_W'(tap);
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          job_nxt   = q_data;
          x_nxt     = job_nxt.xf;
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (j_r == two_r) begin
          state_nxt = S_SUM;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_SUM: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = acc_r[rff_pkg::SUM_SHIFT +: rff_pkg::PIX_W];
          ol_nxt = job_r.ends && at_last;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            x_nxt     = x_r + 1'b1;
            j_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    x_r    <= x_nxt;
    j_r    <= j_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> j_r <= two_r) else $error("tap counter overrun");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> x_r <= job_r.xl) else $error("column past job end");
  a_sum_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH |-> !pv_r) else $error("product pending at push");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(ov_r) |-> $past(out_tready))
    else $error("result dropped");
`endif

endmodule

>>> design/row_fir_filter_truncated_border.sv
// Row FIR filter, truncated border: top level with configuration registers.
// Instantiates rff_front, rff_queue and rff_back; uses rff_pkg.
`timescale 1ns / 1ps

// Each pixel beat is taken by the front end and, if it yields results,
// queued as a job (two-entry queue). The back end has one
// multiply-accumulate unit, which runs one product per tap for each result;
// a row's last pixel yields up to radius+1 results. The front end keeps
// taking pixels while the back end works on earlier jobs, until the queue
// is full, and the back end waits while out_tready stays low.
// Pixels at the start of a row that yield no result are not queued.
// in_tready drops while the job queue is full. Results lag input by radius
// pixels; the final result of a row carries out_tlast. Configuration writes
// must happen while idle.
module row_fir_filter_truncated_border #(
  parameter int MAX_RADIUS = rff_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = rff_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rff_pkg::PIX_W-1:0]    in_tdata,    // [15:0] pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rff_pkg::PIX_W-1:0]    out_tdata,   // [15:0] filtered
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [rff_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [rff_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int JW = rff_pkg::job_width(MAX_RADIUS, MAX_WIDTH);

  logic [rff_pkg::ROW_WIDTH_W-1:0]  row_width_r;
  logic [rff_pkg::RADIUS_W-1:0]     radius_r;
  logic [rff_pkg::CFG_W-1:0]        tap_reg_r [rff_pkg::NUM_TAP_REG];
  rff_pkg::taps_t                   taps;

  logic          q_push, q_full, q_pop, q_valid;
  logic [JW-1:0] q_in, q_head;

  assign taps = {tap_reg_r[3], tap_reg_r[2], tap_reg_r[1], tap_reg_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rff_pkg::ROW_WIDTH_RST;
      radius_r    <= rff_pkg::RADIUS_RST;
      for (int k = 0; k < rff_pkg::NUM_TAP_REG; k++) begin
        tap_reg_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rff_pkg::CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata[rff_pkg::ROW_WIDTH_W-1:0];
        rff_pkg::CFG_RADIUS:     radius_r     <= cfg_wdata[rff_pkg::RADIUS_W-1:0];
        rff_pkg::CFG_TAPS_0_3:   tap_reg_r[0] <= cfg_wdata;
        rff_pkg::CFG_TAPS_4_7:   tap_reg_r[1] <= cfg_wdata;
        rff_pkg::CFG_TAPS_8_11:  tap_reg_r[2] <= cfg_wdata;
        rff_pkg::CFG_TAPS_12_15: tap_reg_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rff_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .JW         (JW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .row_width  (row_width_r),
    .radius     (radius_r),
    .q_full     (q_full),
    .push       (q_push),
    .job_data   (q_in)
  );

  rff_queue #(
    .DW    (JW),
    .DEPTH (rff_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_data (q_head)
  );

  rff_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .JW         (JW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_head),
    .pop        (q_pop),
    .taps       (taps),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/row_fir_filter_truncated_border_test.sv
// Self-checking bench for row_fir_filter_truncated_border: bursty pixel beats, a stalling
// result side and a scoreboard that predicts every filtered beat and checks it in order.
// Depends on rff_pkg and the block's RTL only.
`timescale 1ns / 1ps

module row_fir_filter_truncated_border_test;
  import rff_pkg::*;

  localparam int WIN_LEN      = 2 * MAX_RADIUS_DEF + 1;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 220;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             last;
  } filt_beat_t;

  class row_fir_scoreboard;
    logic [ROW_WIDTH_W-1:0]    row_width;
    logic [RADIUS_W-1:0]       radius;
    logic [NUM_TAPS*TAP_W-1:0] tap_bits;
    logic [PIX_W-1:0]          window [WIN_LEN];
    int                        column;
    filt_beat_t                expected_q [$];
    int                        errors;
    int                        pixels_seen;
    int                        results_checked;

    function new();
      row_width = ROW_WIDTH_RST;
      radius = RADIUS_RST;
      tap_bits = '0;
      foreach (window[k]) window[k] = '0;
      column = 0;
      errors = 0;
      pixels_seen = 0;
      results_checked = 0;
    endfunction

    function void apply_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ROW_WIDTH:  row_width = val[ROW_WIDTH_W-1:0];
        CFG_RADIUS:     radius = val[RADIUS_W-1:0];
        CFG_TAPS_0_3:   tap_bits[0*CFG_W +: CFG_W] = val;
        CFG_TAPS_4_7:   tap_bits[1*CFG_W +: CFG_W] = val;
        CFG_TAPS_8_11:  tap_bits[2*CFG_W +: CFG_W] = val;
        CFG_TAPS_12_15: tap_bits[3*CFG_W +: CFG_W] = val;
        default: ;
      endcase
    endfunction

    // x: output column, c: column of newest pixel, r: radius
    function logic [PIX_W-1:0] weighted_sum(int x, int c, int r);
      logic [ACC_W-1:0] acc;
      int age;
      int j;
      acc = '0;
      for (int i = x - r; i <= x + r; i++) begin
        if (i < 0 || i > c) continue;
        age = c - i;
        if (age >= WIN_LEN) continue;
        j = i - x + r;
        acc = acc + window[age] * tap_bits[TAP_W*j +: TAP_W];
      end
      return acc[ACC_W-1 -: PIX_W];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int eff_width;
      int r;
      int first;
      int last_col;
      bit ends;
      filt_beat_t b;
      eff_width = int'(row_width);
      if (eff_width == 0 || eff_width > MAX_WIDTH_DEF) eff_width = MAX_WIDTH_DEF;
      r = int'(radius);
      for (int k = WIN_LEN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = pix;
      ends = column >= eff_width - 1;
      first = column - r;
      last_col = ends ? column : first;
      if (first < 0) first = 0;
      for (int x = first; x <= last_col; x++) begin
        b.filtered = weighted_sum(x, column, r);
        b.last = ends && (x == last_col);
        expected_q.push_back(b);
      end
      column = ends ? 0 : column + 1;
      pixels_seen++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [PIX_W-1:0] filtered, logic last);
      filt_beat_t exp_b;
      results_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat filtered=%h last=%b", filtered, last));
        return;
      end
      exp_b = expected_q.pop_front();
      if (filtered !== exp_b.filtered)
        report($sformatf("filtered %h, expected %h", filtered, exp_b.filtered));
      if (last !== exp_b.last)
        report($sformatf("last %b, expected %b", last, exp_b.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata   = '0;    // [15:0] pixel
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [PIX_W-1:0]     out_tdata;          // [15:0] filtered
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IW-1:0]    cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  row_fir_scoreboard sb = new();

  int burst_left  = 0;
  bit steady      = 1'b0;
  int settings    = 0;
  logic hold_req  = 1'b0;
  bit hold_done   = 1'b0;
  int rx_mode     = 0;
  int rx_left     = 0;
  int rx_phase    = 0;
  int idle_cycles = 0;

  row_fir_filter_truncated_border u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.apply_reg(cfg_idx_t'(cfg_index), cfg_wdata);
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_phase % 5) < 3;
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: %0d cycles without any beat", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // stop offering, wait for all results, then let the back end settle
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_filter(int width, int rad, logic [CFG_W-1:0] t0, logic [CFG_W-1:0] t1,
                            logic [CFG_W-1:0] t2, logic [CFG_W-1:0] t3);
    cfg_write(CFG_ROW_WIDTH, CFG_W'(width));
    cfg_write(CFG_RADIUS, CFG_W'(rad));
    cfg_write(CFG_TAPS_0_3, t0);
    cfg_write(CFG_TAPS_4_7, t1);
    cfg_write(CFG_TAPS_8_11, t2);
    cfg_write(CFG_TAPS_12_15, t3);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  function automatic logic [CFG_W-1:0] rand_taps();
    logic [CFG_W-1:0] v;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0: v[TAP_W*k +: TAP_W] = '0;
        1: v[TAP_W*k +: TAP_W] = '1;
        default: v[TAP_W*k +: TAP_W] = TAP_W'($urandom());
      endcase
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  initial begin
    int width;
    int rad;
    int count;
    int random_sent;
    random_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 640-wide rows, radius 1, zero taps
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h1234);
    drain();
    // row shrinks under column 3: next pixel ends the row; full taps wrap the sum
    set_filter(2, 7, '1, '1, '1, '1);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    drain();
    // one-pixel rows, radius 0
    set_filter(1, 0, 64'h0000_0000_0000_FFFF, rand_taps(), rand_taps(), rand_taps());
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h8001);
    drain();
    set_filter(9, 4, rand_taps(), rand_taps(), rand_taps(), rand_taps());
    for (int k = 0; k < 9; k++) send_pixel(k[0] ? 16'h0000 : (k[1] ? rand_pixel() : 16'hFFFF));
    drain();
    // width 0 and 8191 both read as the maximum width
    set_filter(0, 2, rand_taps(), rand_taps(), rand_taps(), rand_taps());
    repeat (3) send_pixel(rand_pixel());
    drain();
    set_filter(8191, 3, rand_taps(), rand_taps(), rand_taps(), rand_taps());
    repeat (2) send_pixel(rand_pixel());
    drain();
    set_filter(3, 5, rand_taps(), rand_taps(), rand_taps(), rand_taps());
    send_pixel(rand_pixel());

    while (random_sent < RANDOM_ITEMS) begin
      drain();
      rad = $urandom_range(0, MAX_RADIUS_DEF);
      case ($urandom_range(0, 9))
        0, 1, 2: width = $urandom_range(1, 2 * rad + 1);
        9: width = $urandom_range(20, 48);
        default: width = $urandom_range(2 * rad + 1, 2 * rad + 12);
      endcase
      set_filter(width, rad, rand_taps(), rand_taps(), rand_taps(), rand_taps());
      steady = ($urandom_range(0, 3) == 0);
      // whole rows, sometimes ending mid-row
      count = $urandom_range(1, 3) * width;
      if ($urandom_range(0, 4) == 0) count += $urandom_range(1, width);
      repeat (count) begin
        if (random_sent < RANDOM_ITEMS) begin
          send_pixel(rand_pixel());
          random_sent++;
          if (random_sent == 70) hold_req <= 1'b1;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixels over %0d filter settings (radius 0..7, widths 0..8191),",
             sb.pixels_seen, settings);
    $display("  %0d filtered beats checked, one long output hold-off included.",
             sb.results_checked);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
